@@ hw/rtl/trace_ring_buffer_unit_macros.svh @@
// Assertion macros of the trace ring buffer checker.
`ifndef TRACE_RING_BUFFER_UNIT_MACROS_SVH
`define TRACE_RING_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while rst is high.
`define TRB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trb check failed");

// Next-cycle implication, ignored while rst is high.
`define TRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trb check failed");

// Next-cycle implication, checked during reset as well.
`define TRB_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("trb check failed");

`endif

@@ hw/rtl/trb_pkg.sv @@
// Shared types, codes and widths of the trace ring buffer.
`timescale 1ns / 1ps
package trb_pkg;

  localparam int SLOTS_DEFAULT  = 1024;
  localparam int POINTS_DEFAULT = 16;

  localparam int TAG_W    = 64;
  localparam int SIDX_W   = 10;
  localparam int PIDX_W   = 4;
  localparam int KIND_W   = 32;
  localparam int TIME_W   = 64;
  localparam int SEQ_W    = 64;
  localparam int WRAP_W   = 32;
  localparam int OUTCNT_W = 5;

  localparam int IN_DATA_W  = 176;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 472;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int CAP_W       = 11;
  localparam int MP_W        = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [MP_W-1:0]  MP_RESET  = 5'd16;

  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_CAPACITY = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_POINTS    = 1'b1;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_FINISH
  } trb_state_t;

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic slot_rd;
    logic exec;
    logic finish;
  } trb_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } trb_stat_t;

endpackage

@@ hw/rtl/trb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module trb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/trb_ctrl.sv @@
// Sequencer of the trace ring buffer: clearing pass and per-word steps.
`timescale 1ns / 1ps
module trb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  trb_pkg::trb_stat_t stat,
  output trb_pkg::trb_cmd_t  cmd
);

  trb_pkg::trb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      trb_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = trb_pkg::ST_IDLE;
      end
      trb_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = trb_pkg::ST_LOOKUP;
      end
      trb_pkg::ST_LOOKUP: state_next = trb_pkg::ST_EXEC;
      trb_pkg::ST_EXEC:   state_next = trb_pkg::ST_FINISH;
      trb_pkg::ST_FINISH: begin
        if (stat.out_free) state_next = trb_pkg::ST_IDLE;
      end
      default: state_next = trb_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      trb_pkg::ST_CLEAR:  cmd.clear_wr = 1'b1;
      trb_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      trb_pkg::ST_LOOKUP: cmd.slot_rd = 1'b1;
      trb_pkg::ST_EXEC:   cmd.exec = 1'b1;
      // hold the result until the output register has room
      trb_pkg::ST_FINISH: cmd.finish = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/trb_datapath.sv @@
// Datapath of the trace ring buffer: config, counters, memories, result register.
`timescale 1ns / 1ps
module trb_datapath #(
  parameter int SLOTS            = trb_pkg::SLOTS_DEFAULT,
  parameter int POINTS_PER_TRACE = trb_pkg::POINTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [trb_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [trb_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [trb_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               cfg_we,
  input  logic [trb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [trb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  trb_pkg::trb_cmd_t                  cmd,
  output trb_pkg::trb_stat_t                 stat
);

  localparam int SW    = $clog2(SLOTS);
  localparam int CW0   = $clog2(SLOTS + 1);
  localparam int CW    = (CW0 > trb_pkg::CAP_W) ? CW0 : trb_pkg::CAP_W;
  localparam int CNTW0 = $clog2(POINTS_PER_TRACE + 2);
  localparam int CNTW  = (CNTW0 > trb_pkg::MP_W) ? CNTW0 : trb_pkg::MP_W;
  localparam int PDEPTH = SLOTS * POINTS_PER_TRACE;
  localparam int PAW   = $clog2(PDEPTH);
  localparam int SLW   = trb_pkg::TAG_W + CNTW;
  localparam int PTW   = trb_pkg::TIME_W + trb_pkg::KIND_W;

  // configuration
  logic [trb_pkg::CAP_W-1:0] cfg_cap;
  logic [trb_pkg::MP_W-1:0]  cfg_mp;
  logic [CW-1:0]             cap_eff;
  logic [CNTW-1:0]           mp_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cap <= trb_pkg::CAP_RESET;
      cfg_mp  <= trb_pkg::MP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        trb_pkg::CFG_SLOT_CAPACITY: cfg_cap <= cfg_data[trb_pkg::CAP_W-1:0];
        trb_pkg::CFG_MAX_POINTS:    cfg_mp  <= cfg_data[trb_pkg::MP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cap_eff = CW'(cfg_cap);
    if (cap_eff == '0) cap_eff = CW'(1);
    else if (cap_eff > CW'(SLOTS)) cap_eff = CW'(SLOTS);
    mp_eff = CNTW'(cfg_mp);
    if (mp_eff == '0) mp_eff = CNTW'(1);
    else if (mp_eff > CNTW'(POINTS_PER_TRACE)) mp_eff = CNTW'(POINTS_PER_TRACE);
  end

  // captured input word
  logic [1:0]                   r_mode;
  logic [trb_pkg::TAG_W-1:0]    r_tag;
  logic [trb_pkg::SIDX_W-1:0]   r_sidx;
  logic [trb_pkg::PIDX_W-1:0]   r_pidx;
  logic [trb_pkg::KIND_W-1:0]   r_kind;
  logic [trb_pkg::TIME_W-1:0]   r_time;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r_mode <= s_tuser;
      r_tag  <= s_tdata[63:0];
      r_sidx <= s_tdata[73:64];
      r_pidx <= s_tdata[77:74];
      r_kind <= s_tdata[109:78];
      r_time <= s_tdata[173:110];
    end
  end

  // clearing pass over the slot memory
  logic [SW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx <= clr_idx + SW'(1);
    end
  end

  // counters; the sequence number and the allocation total always agree
  logic [trb_pkg::SEQ_W-1:0]  next_seq;
  logic [SW-1:0]              write_slot;
  logic [trb_pkg::WRAP_W-1:0] pass_cnt;
  logic [trb_pkg::SEQ_W-1:0]  drop_cnt;

  // memories
  logic            slot_we;
  logic [SW-1:0]   slot_waddr;
  logic [SLW-1:0]  slot_wdata;
  logic [SLW-1:0]  slot_rdata;
  logic [SW-1:0]   slot_addr;
  logic            pt_we;
  logic            pt_re;
  logic [PAW-1:0]  pt_waddr;
  logic [PAW-1:0]  pt_raddr;
  logic [PTW-1:0]  pt_rdata;

  logic [31:0] sidx_wide;
  assign sidx_wide = 32'(r_sidx);
  assign slot_addr = sidx_wide[SW-1:0];

  trb_ram #(.WIDTH(SLW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.slot_rd),
    .raddr (slot_addr),
    .rdata (slot_rdata)
  );

  trb_ram #(.WIDTH(PTW), .DEPTH(PDEPTH)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata ({r_time, r_kind}),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // per-word update
  logic [CNTW-1:0]           slot_cnt;
  logic [trb_pkg::TAG_W-1:0] slot_tag_rd;
  logic                      in_range;
  logic [SW-1:0]             alloc_slot;
  logic [CW-1:0]             alloc_inc;
  logic [SW-1:0]             alloc_after;
  logic [CNTW-1:0]           kept;
  logic                      full;
  logic [PAW-1:0]            pt_base;
  logic [CNTW-1:0]           add_cnt;
  logic                      e_slot_we;
  logic [SW-1:0]             e_slot_waddr;
  logic [SLW-1:0]            e_slot_wdata;
  logic                      e_pt_we;
  logic                      e_pt_re;
  logic [trb_pkg::SIDX_W-1:0] e_given;
  logic [trb_pkg::TAG_W-1:0] e_tag;
  logic [CNTW-1:0]           e_cnt;
  logic                      e_drop;
  logic                      e_hit;
  logic                      e_alloc;

  always_comb begin
    slot_cnt    = slot_rdata[CNTW-1:0];
    slot_tag_rd = slot_rdata[SLW-1:CNTW];
    in_range    = CW'(r_sidx) < cap_eff;
    alloc_slot  = (CW'(write_slot) >= cap_eff) ? '0 : write_slot;
    alloc_inc   = CW'(alloc_slot) + CW'(1);
    alloc_after = (alloc_inc >= cap_eff) ? '0 : alloc_inc[SW-1:0];
    kept        = (slot_cnt < mp_eff) ? slot_cnt : mp_eff;
    full        = slot_cnt >= mp_eff;
    pt_base     = PAW'(slot_addr) * PAW'(POINTS_PER_TRACE);
    pt_waddr    = pt_base + PAW'(slot_cnt);
    pt_raddr    = pt_base + PAW'(r_pidx);
    add_cnt     = full ? (mp_eff + CNTW'(1)) : (slot_cnt + CNTW'(1));

    e_slot_we    = 1'b0;
    e_slot_waddr = slot_addr;
    e_slot_wdata = {slot_tag_rd, add_cnt};
    e_pt_we      = 1'b0;
    e_pt_re      = 1'b0;
    e_given      = r_sidx;
    e_tag        = '0;
    e_cnt        = '0;
    e_drop       = 1'b0;
    e_hit        = 1'b0;
    e_alloc      = 1'b0;
    case (r_mode)
      trb_pkg::MODE_ALLOC: begin
        e_alloc      = 1'b1;
        e_slot_we    = 1'b1;
        e_slot_waddr = alloc_slot;
        e_slot_wdata = {r_tag, CNTW'(0)};
        e_given      = trb_pkg::SIDX_W'(alloc_slot);
        e_tag        = r_tag;
      end
      trb_pkg::MODE_ADD: begin
        if (in_range) begin
          e_slot_we = 1'b1;
          e_pt_we   = !full;
          e_drop    = full;
          e_tag     = slot_tag_rd;
          e_cnt     = add_cnt;
        end
      end
      trb_pkg::MODE_READ: begin
        if (in_range) begin
          e_hit   = CNTW'(r_pidx) < kept;
          e_pt_re = e_hit;
          e_tag   = slot_tag_rd;
          e_cnt   = slot_cnt;
        end
      end
      trb_pkg::MODE_NOP: ;
      default: ;
    endcase

    slot_we    = cmd.clear_wr || (cmd.exec && e_slot_we);
    slot_waddr = cmd.clear_wr ? clr_idx : e_slot_waddr;
    slot_wdata = cmd.clear_wr ? '0 : e_slot_wdata;
    pt_we      = cmd.exec && e_pt_we;
    pt_re      = cmd.exec && e_pt_re;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq   <= '0;
      write_slot <= '0;
      pass_cnt   <= '0;
      drop_cnt   <= '0;
    end else if (cmd.exec) begin
      if (e_alloc) begin
        if (alloc_slot == '0 && next_seq != '0) pass_cnt <= pass_cnt + 32'd1;
        next_seq   <= next_seq + 64'd1;
        write_slot <= alloc_after;
      end
      if (e_drop) drop_cnt <= drop_cnt + 64'd1;
    end
  end

  // staged slot fields
  logic [trb_pkg::SIDX_W-1:0] s_given;
  logic [trb_pkg::TAG_W-1:0]  s_tag;
  logic [CNTW-1:0]            s_cnt;
  logic                       s_valid;
  logic                       s_drop;
  logic                       s_hit;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      s_given <= e_given;
      s_tag   <= e_tag;
      s_cnt   <= e_cnt;
      s_valid <= (e_cnt != '0) && (e_cnt <= mp_eff);
      s_drop  <= e_drop;
      s_hit   <= e_hit;
    end
  end

  // result register
  logic [trb_pkg::SEQ_W-1:0]  oldest;
  logic [trb_pkg::KIND_W-1:0] rd_kind;
  logic [trb_pkg::TIME_W-1:0] rd_time;

  always_comb begin
    oldest  = ((pass_cnt != '0) && (next_seq >= 64'(cap_eff))) ?
              (next_seq - 64'(cap_eff)) : '0;
    rd_kind = s_hit ? pt_rdata[trb_pkg::KIND_W-1:0] : '0;
    rd_time = s_hit ? pt_rdata[PTW-1:trb_pkg::KIND_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {7'd0, next_seq, drop_cnt, pass_cnt, next_seq, oldest, s_drop,
                  rd_time, rd_kind, s_valid, trb_pkg::OUTCNT_W'(s_cnt), s_tag, s_given};
    end
  end

  assign stat.clear_last = clr_idx == SW'(SLOTS - 1);
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

@@ hw/rtl/trace_ring_buffer_unit.sv @@
// Top level of the trace ring buffer: sequencer plus datapath.
`timescale 1ns / 1ps
// Circular trace store. Each input word (tuser = mode) either claims the next ring
// slot for a request tag, appends a (kind, time) point to a slot (dropping it when
// the slot is full), reads one slot and one of its points, or does nothing; each
// word yields exactly one result word carrying the slot view and the running
// counters. The result word is valid once its accepted input word has passed the
// slot memory read, the update with point memory access and the result load; the
// load waits while the output register is full, and no new word is accepted before
// the previous one is loaded. A new word is taken while the previous result still
// waits downstream. After reset a clearing pass zeroes the whole slot memory; no
// word is accepted during it, configuration writes are taken. Point memory is not
// cleared; only points below a slot's count are ever returned.
module trace_ring_buffer_unit #(
  parameter int SLOTS            = trb_pkg::SLOTS_DEFAULT,
  parameter int POINTS_PER_TRACE = trb_pkg::POINTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // request_tag[63:0], slot_index[73:64], point_index[77:74],
  // point_kind[109:78], point_time[173:110], zero[175:174]
  input  logic [trb_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode[1:0]
  input  logic [trb_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // given_slot[9:0], slot_tag[73:10], slot_points[78:74], slot_valid[79],
  // read_kind[111:80], read_time[175:112], point_dropped[176],
  // oldest_seq[240:177], next_seq[304:241], wrap_total[336:305],
  // drop_total[400:337], trace_total[464:401], zero[471:465]
  output logic [trb_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [trb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [trb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  trb_pkg::trb_cmd_t  cmd;
  trb_pkg::trb_stat_t stat;

  trb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trb_datapath #(
    .SLOTS            (SLOTS),
    .POINTS_PER_TRACE (POINTS_PER_TRACE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ hw/rtl/trb_checker.sv @@
// Port-level checks of the trace ring buffer, bound to the top level.
`timescale 1ns / 1ps
`include "trace_ring_buffer_unit_macros.svh"
module trb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [trb_pkg::OUT_DATA_W-1:0] m_tdata
);

  `TRB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `TRB_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
  // one word at a time: acceptance is never followed by a second at once
  `TRB_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  // reset starts the clearing pass, which blocks input
  `TRB_ASSERT_NEXT_ALWAYS(a_reset_blocks, rst, !s_tready)
  // a dropped point always leaves its slot marked overflowed
  `TRB_ASSERT_IMPLY(a_drop_invalid, m_tvalid && m_tdata[176], !m_tdata[79])

endmodule

bind trace_ring_buffer_unit trb_checker u_trb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
